/* sv/assert_macros.svh */
// Assertion macros used by the top level of the interpolator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the cycle where ante holds.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/bti_pkg.sv */
// Types, widths and codes shared by the bilinear table interpolator files.
package bti_pkg;

	localparam int WORD_W     = 16;
	localparam int CMD_W      = 2;
	localparam int ROW_IDX_W  = 3;
	localparam int COL_IDX_W  = 4;
	localparam int ROWS_W     = 4;
	localparam int COLS_W     = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	localparam logic [CMD_W-1:0] CMD_LOAD_GRID = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_ROW  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LOAD_COL  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_QUERY     = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

	localparam logic [ROWS_W-1:0] ROWS_RST = 4'd6;
	localparam logic [COLS_W-1:0] COLS_RST = 5'd15;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		word_t x;
		word_t x0;
		word_t x1;
		word_t f0;
		word_t f1;
	} blend_req_t;

	typedef struct packed {
		logic  busy;
		logic  done;
		word_t value;
	} blend_sts_t;

endpackage

/* sv/bti_if.sv */
// Item channels of the interpolator: request items in, result items out.
interface bti_req_if import bti_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     cmd;
	logic                 table_sel;
	logic [ROW_IDX_W-1:0] row_index;
	logic [COL_IDX_W-1:0] col_index;
	word_t                load_word;
	word_t                row_ratio;
	word_t                col_ratio;

	modport source (output valid, cmd, table_sel, row_index, col_index, load_word,
		row_ratio, col_ratio, input ready);
	modport sink (input valid, cmd, table_sel, row_index, col_index, load_word,
		row_ratio, col_ratio, output ready);
endinterface

interface bti_rsp_if import bti_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t result_value;
	logic  out_of_range;

	modport source (output valid, result_value, out_of_range, input ready);
	modport sink (input valid, result_value, out_of_range, output ready);
endinterface

/* sv/bti_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module bti_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/bti_blend.sv */
// Shared blend unit: one multiply, then a bit-serial rounded division.
module bti_blend import bti_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  blend_req_t req,
	output blend_sts_t sts
);

	localparam int W     = WORD_W;
	localparam int CNT_W = $clog2(W);

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_MUL  = 3'd1;
	localparam logic [2:0] B_ADD  = 3'd2;
	localparam logic [2:0] B_DIV  = 3'd3;
	localparam logic [2:0] B_FIN  = 3'd4;

	logic [2:0]       st_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	word_t            dx_q;
	word_t            off_q;
	word_t            df_q;
	word_t            f0_q;
	logic             neg_q;
	logic [2*W-1:0]   prod_q;
	word_t            rem_q;
	word_t            sh_q;
	word_t            value_q;

	logic [2*W:0]     num;
	logic [W:0]       trial;
	logic [W:0]       diff;
	logic             fits;
	word_t            rem_nx;

	always_comb begin
		num    = {1'b0, prod_q} + {{(W+1){1'b0}}, dx_q >> 1};
		trial  = {rem_q, sh_q[W-1]};
		diff   = trial - {1'b0, dx_q};
		fits   = trial >= {1'b0, dx_q};
		rem_nx = fits ? diff[W-1:0] : trial[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= B_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				B_IDLE: begin
					if (start) begin
						st_q <= B_MUL;
					end
				end
				B_MUL: st_q <= B_ADD;
				B_ADD: begin
					cnt_q <= '0;
					st_q  <= B_DIV;
				end
				B_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(W - 1)) begin
						st_q <= B_FIN;
					end
				end
				B_FIN: begin
					done_q <= 1'b1;
					st_q   <= B_IDLE;
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == B_IDLE && start) begin
			dx_q  <= req.x1 - req.x0;
			off_q <= req.x - req.x0;
			neg_q <= req.f1 < req.f0;
			df_q  <= (req.f1 < req.f0) ? req.f0 - req.f1 : req.f1 - req.f0;
			f0_q  <= req.f0;
		end
		if (st_q == B_MUL) begin
			prod_q <= df_q * off_q;
		end
		if (st_q == B_ADD) begin
			rem_q <= num[2*W-1:W];
			sh_q  <= num[W-1:0];
		end
		if (st_q == B_DIV) begin
			rem_q <= rem_nx;
			sh_q  <= {sh_q[W-2:0], fits};
		end
		if (st_q == B_FIN) begin
			value_q <= neg_q ? f0_q - sh_q : f0_q + sh_q;
		end
	end

	assign sts.busy  = st_q != B_IDLE;
	assign sts.done  = done_q;
	assign sts.value = value_q;

endmodule

/* sv/bilinear_table_interpolator.sv */
// Top level of the bilinear table interpolator: key search sequencer and grid storage.
//
//  channel | dir | payload                                                     | accept
//  req     | in  | cmd table_sel row_index col_index load_word row/col_ratio  | valid & ready
//  rsp     | out | result_value out_of_range                                   | valid & ready
//  cfg     | in  | cfg_index cfg_data (rows_in_use, cols_in_use)              | cfg_we
//
// Load items are written when accepted and leave the input ready. A query keeps the input off
// from its acceptance to its push: serial key searches for row and column, a grid read of each
// row used with its column blend where needed, the row blend where needed, then the push.
// Reset sets rows_in_use to 6 and cols_in_use to 15; grid and keys stay undefined until
// loaded, with no clearing pass. A result waits in the output register while loads and
// the next query run; that query completes once the register is free.
`include "assert_macros.svh"

module bilinear_table_interpolator import bti_pkg::*; #(
	parameter int MAX_ROWS  = 8,
	parameter int MAX_COLS  = 16,
	parameter int NUM_GRIDS = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	bti_req_if.sink               req,
	bti_rsp_if.source             rsp
);

	localparam int RKW   = $clog2(MAX_ROWS);
	localparam int CKW   = $clog2(MAX_COLS);
	localparam int KW    = (RKW > CKW) ? RKW : CKW;
	localparam int GSW   = (NUM_GRIDS > 1) ? $clog2(NUM_GRIDS) : 1;
	localparam int RC    = MAX_ROWS * MAX_COLS;
	localparam int GDEP  = NUM_GRIDS * RC;
	localparam int GA    = $clog2(GDEP);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_LFIRST = 4'd1;
	localparam logic [3:0] S_LLAST = 4'd2;
	localparam logic [3:0] S_LCHK  = 4'd3;
	localparam logic [3:0] S_LSCAN = 4'd4;
	localparam logic [3:0] S_GROW  = 4'd5;
	localparam logic [3:0] S_GA    = 4'd6;
	localparam logic [3:0] S_GB    = 4'd7;
	localparam logic [3:0] S_GWC   = 4'd8;
	localparam logic [3:0] S_GWR   = 4'd9;
	localparam logic [3:0] S_PUSH  = 4'd10;

	logic [3:0]        st_q;
	logic [3:0]        st_d;
	logic [ROWS_W-1:0] rows_q;
	logic [COLS_W-1:0] cols_q;
	logic              which_q;
	logic              pass_q;
	logic              out_valid_q;

	logic [GSW-1:0]    sel_q;
	word_t             xr_q;
	word_t             xc_q;
	logic [KW-1:0]     rlast_q;
	logic [KW-1:0]     clast_q;
	logic              clamp_q;
	logic [KW-1:0]     idx_q;
	word_t             prev_q;
	logic [KW-1:0]     r_q;
	logic              rsing_q;
	word_t             rx0_q;
	word_t             rx1_q;
	logic [KW-1:0]     c_q;
	logic              csing_q;
	word_t             cx0_q;
	word_t             cx1_q;
	word_t             fa_q;
	word_t             g0_q;
	word_t             final_q;
	word_t             res_q;
	logic              flag_q;

	logic              req_acc;
	logic              query_acc;
	logic              push;
	logic [7:0]        nr8;
	logic [7:0]        nc8;
	logic [GSW-1:0]    sel_d;

	word_t             kd;
	word_t             lx;
	logic [KW-1:0]     loc_last;
	logic              loc_done;
	logic [KW-1:0]     loc_idx;
	logic              loc_single;
	logic              loc_clamp;
	logic [KW-1:0]     loc_addr;

	logic [KW-1:0]     row_cur;
	logic [KW-1:0]     col_cur;
	logic              row_done;
	word_t             row_val;

	logic              grid_we;
	logic [GA-1:0]     grid_waddr;
	logic [GA-1:0]     grid_raddr;
	word_t             grid_rd;
	logic              rkey_we;
	logic              ckey_we;
	word_t             row_rd;
	word_t             col_rd;

	logic              bl_start;
	blend_req_t        bl_req;
	blend_sts_t        bl_sts;

	assign req.ready = st_q == S_IDLE;
	assign req_acc   = req.valid && req.ready;
	assign query_acc = req_acc && req.cmd == CMD_QUERY;
	assign push      = st_q == S_PUSH && (!out_valid_q || rsp.ready);

	assign rsp.valid        = out_valid_q;
	assign rsp.result_value = res_q;
	assign rsp.out_of_range = flag_q;

	always_comb begin
		nr8 = {4'b0, rows_q};
		if (rows_q < 4'd2) begin
			nr8 = 8'd2;
		end else if ({4'b0, rows_q} > 8'(MAX_ROWS)) begin
			nr8 = 8'(MAX_ROWS);
		end
		nc8 = {3'b0, cols_q};
		if (cols_q < 5'd2) begin
			nc8 = 8'd2;
		end else if ({3'b0, cols_q} > 8'(MAX_COLS)) begin
			nc8 = 8'(MAX_COLS);
		end
		sel_d = (int'(req.table_sel) >= NUM_GRIDS) ? GSW'(NUM_GRIDS - 1) : GSW'(req.table_sel);
	end

	// Load writes.
	always_comb begin
		grid_we    = req_acc && req.cmd == CMD_LOAD_GRID && int'(req.table_sel) < NUM_GRIDS
			&& int'(req.row_index) < MAX_ROWS && int'(req.col_index) < MAX_COLS;
		grid_waddr = GA'(RC * int'(req.table_sel) + MAX_COLS * int'(req.row_index)
			+ int'(req.col_index));
		rkey_we    = req_acc && req.cmd == CMD_LOAD_ROW && int'(req.row_index) < MAX_ROWS;
		ckey_we    = req_acc && req.cmd == CMD_LOAD_COL && int'(req.col_index) < MAX_COLS;
	end

	// Shared key search: one compare per cycle against the key read the cycle before.
	always_comb begin
		kd         = which_q ? col_rd : row_rd;
		lx         = which_q ? xc_q : xr_q;
		loc_last   = which_q ? clast_q : rlast_q;
		loc_done   = 1'b0;
		loc_idx    = idx_q;
		loc_single = 1'b1;
		loc_clamp  = 1'b0;
		if (st_q == S_LLAST && lx <= kd) begin
			loc_done  = 1'b1;
			loc_idx   = '0;
			loc_clamp = lx < kd;
		end else if (st_q == S_LCHK && lx >= kd) begin
			loc_done  = 1'b1;
			loc_idx   = loc_last;
			loc_clamp = lx > kd;
		end else if (st_q == S_LSCAN && kd >= lx) begin
			loc_done   = 1'b1;
			loc_single = kd == lx;
		end
		unique case (st_q)
			S_LLAST: loc_addr = loc_last;
			S_LCHK:  loc_addr = KW'(1);
			S_LSCAN: loc_addr = idx_q + 1'b1;
			default: loc_addr = '0;
		endcase
	end

	// Grid reads and row completion.
	always_comb begin
		row_cur    = (!rsing_q && !pass_q) ? r_q - 1'b1 : r_q;
		col_cur    = (st_q == S_GROW && !csing_q) ? c_q - 1'b1 : c_q;
		grid_raddr = GA'(RC * int'(sel_q) + MAX_COLS * int'(row_cur) + int'(col_cur));
		row_done   = (st_q == S_GA && csing_q) || (st_q == S_GWC && bl_sts.done);
		row_val    = (st_q == S_GA) ? grid_rd : bl_sts.value;
		bl_start   = (st_q == S_GB) || (row_done && !rsing_q && pass_q);
		if (st_q == S_GB) begin
			bl_req.x  = xc_q;
			bl_req.x0 = cx0_q;
			bl_req.x1 = cx1_q;
			bl_req.f0 = fa_q;
			bl_req.f1 = grid_rd;
		end else begin
			bl_req.x  = xr_q;
			bl_req.x0 = rx0_q;
			bl_req.x1 = rx1_q;
			bl_req.f0 = g0_q;
			bl_req.f1 = row_val;
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			S_IDLE: begin
				if (query_acc) begin
					st_d = S_LFIRST;
				end
			end
			S_LFIRST: st_d = S_LLAST;
			S_LLAST, S_LCHK, S_LSCAN: begin
				if (loc_done) begin
					st_d = which_q ? S_GROW : S_LFIRST;
				end else if (st_q == S_LLAST) begin
					st_d = S_LCHK;
				end else begin
					st_d = S_LSCAN;
				end
			end
			S_GROW: st_d = S_GA;
			S_GA, S_GWC: begin
				if (row_done) begin
					priority if (rsing_q) begin
						st_d = S_PUSH;
					end else if (!pass_q) begin
						st_d = S_GROW;
					end else begin
						st_d = S_GWR;
					end
				end else if (st_q == S_GA) begin
					st_d = S_GB;
				end
			end
			S_GB: st_d = S_GWC;
			S_GWR: begin
				if (bl_sts.done) begin
					st_d = S_PUSH;
				end
			end
			S_PUSH: begin
				if (push) begin
					st_d = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			rows_q      <= ROWS_RST;
			cols_q      <= COLS_RST;
			which_q     <= 1'b0;
			pass_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ROWS: rows_q <= cfg_data[ROWS_W-1:0];
					REG_COLS: cols_q <= cfg_data[COLS_W-1:0];
				endcase
			end
			if (query_acc) begin
				which_q <= 1'b0;
			end else if (loc_done && !which_q) begin
				which_q <= 1'b1;
			end
			if (loc_done && which_q) begin
				pass_q <= 1'b0;
			end else if (row_done && !rsing_q && !pass_q) begin
				pass_q <= 1'b1;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (query_acc) begin
			sel_q   <= sel_d;
			xr_q    <= req.row_ratio;
			xc_q    <= req.col_ratio;
			rlast_q <= KW'(nr8 - 8'd1);
			clast_q <= KW'(nc8 - 8'd1);
			clamp_q <= 1'b0;
		end
		if (st_q == S_LLAST && !loc_done) begin
			prev_q <= kd;
		end
		if (st_q == S_LCHK && !loc_done) begin
			idx_q <= KW'(1);
		end
		if (st_q == S_LSCAN && !loc_done) begin
			prev_q <= kd;
			idx_q  <= idx_q + 1'b1;
		end
		if (loc_done) begin
			clamp_q <= clamp_q | loc_clamp;
			if (!which_q) begin
				r_q     <= loc_idx;
				rsing_q <= loc_single;
				rx0_q   <= prev_q;
				rx1_q   <= kd;
			end else begin
				c_q     <= loc_idx;
				csing_q <= loc_single;
				cx0_q   <= prev_q;
				cx1_q   <= kd;
			end
		end
		if (st_q == S_GA && !csing_q) begin
			fa_q <= grid_rd;
		end
		if (row_done && !rsing_q && !pass_q) begin
			g0_q <= row_val;
		end
		if (row_done && rsing_q) begin
			final_q <= row_val;
		end
		if (st_q == S_GWR && bl_sts.done) begin
			final_q <= bl_sts.value;
		end
		if (push) begin
			res_q  <= final_q;
			flag_q <= clamp_q;
		end
	end

	bti_ram #(.WIDTH(WORD_W), .DEPTH(GDEP)) u_grid (
		.clk   (clk),
		.we    (grid_we),
		.waddr (grid_waddr),
		.wdata (req.load_word),
		.raddr (grid_raddr),
		.rdata (grid_rd)
	);

	bti_ram #(.WIDTH(WORD_W), .DEPTH(MAX_ROWS)) u_row_keys (
		.clk   (clk),
		.we    (rkey_we),
		.waddr (RKW'(int'(req.row_index))),
		.wdata (req.load_word),
		.raddr (loc_addr[RKW-1:0]),
		.rdata (row_rd)
	);

	bti_ram #(.WIDTH(WORD_W), .DEPTH(MAX_COLS)) u_col_keys (
		.clk   (clk),
		.we    (ckey_we),
		.waddr (CKW'(int'(req.col_index))),
		.wdata (req.load_word),
		.raddr (loc_addr[CKW-1:0]),
		.rdata (col_rd)
	);

	bti_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bl_start),
		.req    (bl_req),
		.sts    (bl_sts)
	);

	`ASSERT_IMPL(a_blend_free, bl_start, !bl_sts.busy, "blend started while unit busy")
	`ASSERT_IMPL(a_scan_bound, st_q == S_LSCAN, idx_q <= loc_last, "key scan past last key")
	`ASSERT_IMPL(a_push_src, $rose(out_valid_q), $past(st_q == S_PUSH), "result outside push")
	`ASSERT_NEXT(a_row_to_col, loc_done && !which_q, which_q && st_q == S_LFIRST, "no column search")

endmodule

/* sim/bti_result_checker.sv */
// Result checker for the interpolator: tracks its tables and registers, predicts each query result.
module bti_result_checker import bti_pkg::*; #(
	parameter int MAX_ROWS  = 8,
	parameter int MAX_COLS  = 16,
	parameter int NUM_GRIDS = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	bti_req_if                    req,
	bti_rsp_if                    rsp,
	output int                    fail_count,
	output int                    pending
);

	typedef struct packed {
		word_t value;
		logic  out_of_range;
	} interp_t;

	localparam int COL_BASE = MAX_ROWS;

	word_t             grid_mem [NUM_GRIDS*MAX_ROWS*MAX_COLS];
	word_t             key_mem [MAX_ROWS+MAX_COLS];
	logic [ROWS_W-1:0] rows_cfg = ROWS_RST;
	logic [COLS_W-1:0] cols_cfg = COLS_RST;
	interp_t           want_q [$];
	interp_t           want;

	function automatic int span_count(input int v, input int hi);
		return (v < 2) ? 2 : (v > hi) ? hi : v;
	endfunction

	// 1: use entry idx alone; 0: blend entries idx-1 and idx
	function automatic bit find_span(input int base, input int n, input int x,
			output int idx, inout bit clamped);
		int i;
		if (x <= int'(key_mem[base])) begin
			idx = 0;
			if (x < int'(key_mem[base])) clamped = 1'b1;
			return 1'b1;
		end
		if (x >= int'(key_mem[base + n - 1])) begin
			idx = n - 1;
			if (x > int'(key_mem[base + n - 1])) clamped = 1'b1;
			return 1'b1;
		end
		for (i = 1; i < n; i++) begin
			if (int'(key_mem[base + i]) >= x) begin
				idx = i;
				return int'(key_mem[base + i]) == x;
			end
		end
		idx = n - 1;
		return 1'b1;
	endfunction

	function automatic word_t blend(input longint x, x0, x1, f0, f1);
		longint dx;
		longint q;
		dx = x1 - x0;
		if (f1 >= f0) begin
			q = ((f1 - f0) * (x - x0) + dx / 2) / dx;
			return word_t'(f0 + q);
		end
		q = ((f0 - f1) * (x - x0) + dx / 2) / dx;
		return word_t'(f0 - q);
	endfunction

	function automatic word_t row_blend(input int g, input int r, input int x, input int nc,
			inout bit clamped);
		int c;
		int row_base;
		row_base = (g * MAX_ROWS + r) * MAX_COLS;
		if (find_span(COL_BASE, nc, x, c, clamped)) return grid_mem[row_base + c];
		return blend(x, key_mem[COL_BASE + c - 1], key_mem[COL_BASE + c],
			grid_mem[row_base + c - 1], grid_mem[row_base + c]);
	endfunction

	function automatic interp_t interpolate(input logic sel, input word_t xr, input word_t xc);
		int      g;
		int      nr;
		int      nc;
		int      r;
		bit      clamped;
		word_t   g0;
		word_t   g1;
		interp_t res;
		g = (int'(sel) >= NUM_GRIDS) ? NUM_GRIDS - 1 : int'(sel);
		nr = span_count(int'(rows_cfg), MAX_ROWS);
		nc = span_count(int'(cols_cfg), MAX_COLS);
		clamped = 1'b0;
		if (find_span(0, nr, int'(xr), r, clamped)) begin
			res.value = row_blend(g, r, int'(xc), nc, clamped);
		end else begin
			g0 = row_blend(g, r - 1, int'(xc), nc, clamped);
			g1 = row_blend(g, r, int'(xc), nc, clamped);
			res.value = blend(xr, key_mem[r - 1], key_mem[r], g0, g1);
		end
		res.out_of_range = clamped;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want_val);
		$display("mismatch at %0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want_val);
		fail_count++;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			rows_cfg = ROWS_RST;
			cols_cfg = COLS_RST;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_ROWS) rows_cfg = cfg_data[ROWS_W-1:0];
				if (cfg_index == REG_COLS) cols_cfg = cfg_data[COLS_W-1:0];
			end
			if (req.valid && req.ready) begin
				case (req.cmd)
					CMD_LOAD_GRID: begin
						grid_mem[(int'(req.table_sel) * MAX_ROWS + int'(req.row_index)) * MAX_COLS
							+ int'(req.col_index)] = req.load_word;
					end
					CMD_LOAD_ROW: key_mem[int'(req.row_index)] = req.load_word;
					CMD_LOAD_COL: key_mem[COL_BASE + int'(req.col_index)] = req.load_word;
					default: want_q.push_back(interpolate(req.table_sel, req.row_ratio,
						req.col_ratio));
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (want_q.size() == 0) begin
					report_mismatch("result with no query outstanding, result_value",
						rsp.result_value, 0);
				end else begin
					want = want_q.pop_front();
					if (rsp.result_value !== want.value)
						report_mismatch("result_value", rsp.result_value, want.value);
					if (rsp.out_of_range !== want.out_of_range)
						report_mismatch("out_of_range", rsp.out_of_range, want.out_of_range);
				end
			end
		end
		pending = want_q.size();
	end

endmodule

/* sim/tb.sv */
// Testbench top: drives config writes, load and query items into the interpolator and gives the verdict.
module tb;
	import bti_pkg::*;

	localparam int MAX_ROWS    = 8;
	localparam int MAX_COLS    = 16;
	localparam int NUM_GRIDS   = 2;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 150;
	localparam int SETTLE      = 150;
	localparam int LIMIT       = 1000000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count;
	int                    pending;
	int                    cycles = 0;
	int                    idle_pct = 0;
	int                    stall_pct = 0;
	int                    rows_used = 6;
	int                    cols_used = 15;
	word_t                 row_key [MAX_ROWS];
	word_t                 col_key [MAX_COLS];

	bti_req_if req_ch ();
	bti_rsp_if rsp_ch ();

	bilinear_table_interpolator #(
		.MAX_ROWS  (MAX_ROWS),
		.MAX_COLS  (MAX_COLS),
		.NUM_GRIDS (NUM_GRIDS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	bti_result_checker #(
		.MAX_ROWS  (MAX_ROWS),
		.MAX_COLS  (MAX_COLS),
		.NUM_GRIDS (NUM_GRIDS)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	initial begin
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("status: fail");
		$finish;
	end

	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic sel,
			input logic [ROW_IDX_W-1:0] ri, input logic [COL_IDX_W-1:0] ci,
			input word_t word, input word_t xr, input word_t xc);
		while ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.cmd       <= cmd;
		req_ch.table_sel <= sel;
		req_ch.row_index <= ri;
		req_ch.col_index <= ci;
		req_ch.load_word <= word;
		req_ch.row_ratio <= xr;
		req_ch.col_ratio <= xc;
		do @(posedge clk); while (!req_ch.ready);
		if (cmd == CMD_LOAD_ROW) row_key[ri] = word;
		if (cmd == CMD_LOAD_COL) col_key[ci] = word;
	endtask

	task automatic load_item(input logic [CMD_W-1:0] cmd, input logic sel, input int ri,
			input int ci, input word_t word);
		send_item(cmd, sel, ROW_IDX_W'(ri), COL_IDX_W'(ci), word, word_t'($urandom),
			word_t'($urandom));
	endtask

	task automatic query_item(input logic sel, input word_t xr, input word_t xc);
		send_item(CMD_QUERY, sel, ROW_IDX_W'($urandom), COL_IDX_W'($urandom),
			word_t'($urandom), xr, xc);
	endtask

	// one increasing key per bin; full_span pins the outer keys to 0 and full scale
	task automatic load_keys(input bit full_span);
		int    i;
		word_t k;
		for (i = 0; i < MAX_ROWS; i++) begin
			k = word_t'(i * (65536 / MAX_ROWS) + $urandom_range(1, 65536 / MAX_ROWS - 2));
			if (full_span && i == 0) k = '0;
			if (full_span && i == MAX_ROWS - 1) k = '1;
			load_item(CMD_LOAD_ROW, 1'($urandom), i, $urandom, k);
		end
		for (i = 0; i < MAX_COLS; i++) begin
			k = word_t'(i * (65536 / MAX_COLS) + $urandom_range(1, 65536 / MAX_COLS - 2));
			if (full_span && i == 0) k = '0;
			if (full_span && i == MAX_COLS - 1) k = '1;
			load_item(CMD_LOAD_COL, 1'($urandom), $urandom, i, k);
		end
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_config(input logic [CFG_DATA_W-1:0] rows_val,
			input logic [CFG_DATA_W-1:0] cols_val);
		int v;
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= REG_ROWS;
		cfg_data  <= rows_val;
		@(posedge clk);
		cfg_index <= REG_COLS;
		cfg_data  <= cols_val;
		@(posedge clk);
		cfg_we <= 1'b0;
		v = int'(rows_val[ROWS_W-1:0]);
		rows_used = (v < 2) ? 2 : (v > MAX_ROWS) ? MAX_ROWS : v;
		v = int'(cols_val[COLS_W-1:0]);
		cols_used = (v < 2) ? 2 : (v > MAX_COLS) ? MAX_COLS : v;
	endtask

	function automatic word_t mid(input word_t a, input word_t b);
		return word_t'((int'(a) + int'(b)) / 2);
	endfunction

	function automatic word_t pick_ratio(input bit along_rows);
		int    n;
		int    roll;
		word_t k;
		n = along_rows ? rows_used : cols_used;
		k = along_rows ? row_key[$urandom_range(n - 1)] : col_key[$urandom_range(n - 1)];
		roll = $urandom_range(99);
		if (roll < 20) return k;
		if (roll < 27) return k + 16'd1;
		if (roll < 34) return k - 16'd1;
		if (roll < 39) return '0;
		if (roll < 44) return '1;
		return word_t'($urandom);
	endfunction

	initial begin
		int g;
		int r;
		int c;
		int p;
		int n;
		int roll;
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= '0;
		cfg_data         <= '0;
		req_ch.valid     <= 1'b0;
		req_ch.cmd       <= CMD_LOAD_GRID;
		req_ch.table_sel <= 1'b0;
		req_ch.row_index <= '0;
		req_ch.col_index <= '0;
		req_ch.load_word <= '0;
		req_ch.row_ratio <= '0;
		req_ch.col_ratio <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_keys(1'b0);
		for (g = 0; g < NUM_GRIDS; g++)
			for (r = 0; r < MAX_ROWS; r++)
				for (c = 0; c < MAX_COLS; c++)
					load_item(CMD_LOAD_GRID, 1'(g), r, c, word_t'($urandom));

		query_item(1'b0, '0, '0);
		query_item(1'b1, '1, '1);
		query_item(1'b0, row_key[0], col_key[0]);
		query_item(1'b1, row_key[5], col_key[14]);
		query_item(1'b0, row_key[2], mid(col_key[3], col_key[4]));
		query_item(1'b1, mid(row_key[1], row_key[2]), col_key[7]);
		query_item(1'b0, mid(row_key[3], row_key[4]), mid(col_key[9], col_key[10]));
		query_item(1'b1, mid(row_key[4], row_key[5]), mid(col_key[13], col_key[14]));
		query_item(1'b0, row_key[0] - 16'd1, mid(col_key[0], col_key[1]));
		query_item(1'b1, mid(row_key[0], row_key[1]), col_key[14] + 16'd1);
		query_item(1'b0, row_key[6], col_key[0] - 16'd1);
		query_item(1'b1, row_key[1] + 16'd1, col_key[1] - 16'd1);
		load_item(CMD_LOAD_GRID, 1'b0, 1, 3, 16'hFFFF);
		load_item(CMD_LOAD_GRID, 1'b0, 1, 4, 16'h0000);
		load_item(CMD_LOAD_GRID, 1'b0, 2, 3, 16'h0000);
		load_item(CMD_LOAD_GRID, 1'b0, 2, 4, 16'hFFFF);
		query_item(1'b0, mid(row_key[1], row_key[2]), mid(col_key[3], col_key[4]));
		query_item(1'b0, row_key[1] + 16'd1, col_key[4] - 16'd1);
		load_item(CMD_LOAD_ROW, 1'b0, 3, 0, 16'h0000);
		query_item(1'b1, mid(row_key[2], row_key[4]), mid(col_key[5], col_key[6]));
		load_item(CMD_LOAD_COL, 1'b1, 0, 5, 16'hFFFF);
		query_item(1'b0, mid(row_key[0], row_key[1]), mid(col_key[4], col_key[6]));

		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: write_config(5'd2, 5'd2);
				1: write_config(5'd8, 5'd16);
				2: write_config(5'd0, 5'd0);
				3: write_config(5'd31, 5'd31);
				4: write_config(5'd1, 5'd17);
				5: write_config(5'd9, 5'd1);
				6: write_config(5'($urandom_range(2, 8)), 5'($urandom_range(2, 16)));
				default: write_config(5'($urandom), 5'($urandom));
			endcase
			case (p % 4)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 77;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 77;
				end
				default: begin
					idle_pct  = 26;
					stall_pct = 26;
				end
			endcase
			load_keys(p % 3 == 1);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				roll = $urandom_range(99);
				if (roll < 20)
					load_item(CMD_LOAD_GRID, 1'($urandom), $urandom, $urandom, word_t'($urandom));
				else if (roll < 22)
					load_item(CMD_LOAD_ROW, 1'($urandom), $urandom, $urandom, word_t'($urandom));
				else if (roll < 24)
					load_item(CMD_LOAD_COL, 1'($urandom), $urandom, $urandom, word_t'($urandom));
				else
					query_item(1'($urandom), pick_ratio(1'b1), pick_ratio(1'b0));
			end
		end

		drain();
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* sim.f */
+incdir+sv
sv/bti_pkg.sv
sv/bti_if.sv
sv/bti_ram.sv
sv/bti_blend.sv
sv/bilinear_table_interpolator.sv
sim/bti_result_checker.sv
sim/tb.sv
